### sv/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int ID_BITS    = 16;
   localparam int PRIO_BITS  = 4;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int OCC_BITS   = 5;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic                 valid;
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                 enq;
      logic                 deq;
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } cmd_type;

endpackage

### sv/stable_priority_queue_core.sv
// Bounded priority queue, highest priority out first, equal priorities in
// arrival order. One beat is taken every clock cycle: busy is always low.
// The response beat appears on the cycle after start, for exactly one cycle
// with rsp_valid high, and cannot be held off. The entries sit in a row of
// slot cells that shift toward the tail on enqueue and toward the head on
// dequeue, so each operation is done by that shift alone. Enqueue into a
// full queue is dropped with status full; dequeue from an empty queue
// reports status empty. Id and priority of the response are zero unless an
// entry was dequeued.
module stable_priority_queue_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [spq_pkg::ID_BITS-1:0]   req_task_id,
   input  logic [spq_pkg::PRIO_BITS-1:0] req_task_priority,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [spq_pkg::ID_BITS-1:0]   rsp_out_id,
   output logic [spq_pkg::PRIO_BITS-1:0] rsp_out_priority,
   output logic [spq_pkg::OCC_BITS-1:0]  rsp_occupancy
);

   spq_pkg::entry_type entries [spq_pkg::DEPTH];
   spq_pkg::entry_type left_w  [spq_pkg::DEPTH];
   spq_pkg::entry_type right_w [spq_pkg::DEPTH];
   logic [spq_pkg::DEPTH-1:0] ins_w;
   logic [spq_pkg::DEPTH-1:0] left_ins_w;
   logic [spq_pkg::DEPTH-1:0] valid_vec;
   spq_pkg::cmd_type cmd;

   logic full;
   logic empty;
   logic accept;

   logic [spq_pkg::COUNT_BITS-1:0] count_ff;
   logic [spq_pkg::COUNT_BITS-1:0] count_in;

   logic                          rsp_valid_ff;
   spq_pkg::status_type           rsp_status_ff;
   spq_pkg::status_type           rsp_status_in;
   logic [spq_pkg::ID_BITS-1:0]   rsp_out_id_ff;
   logic [spq_pkg::ID_BITS-1:0]   rsp_out_id_in;
   logic [spq_pkg::PRIO_BITS-1:0] rsp_out_priority_ff;
   logic [spq_pkg::PRIO_BITS-1:0] rsp_out_priority_in;
   logic [spq_pkg::OCC_BITS-1:0]  rsp_occupancy_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign empty  = !entries[0].valid;
   assign full   = entries[spq_pkg::DEPTH-1].valid;

   assign cmd.enq  = accept && (req_opcode == spq_pkg::OP_ENQ) && !full;
   assign cmd.deq  = accept && (req_opcode == spq_pkg::OP_DEQ) && !empty;
   assign cmd.id   = req_task_id;
   assign cmd.prio = req_task_priority;

   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_w[i]     = '0;
         assign left_ins_w[i] = 1'b0;
      end else begin : g_body
         assign left_w[i]     = entries[i-1];
         assign left_ins_w[i] = ins_w[i-1];
      end
      if (i == spq_pkg::DEPTH - 1) begin : g_tail
         assign right_w[i] = '0;
      end else begin : g_mid
         assign right_w[i] = entries[i+1];
      end
      assign valid_vec[i] = entries[i].valid;

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_w[i]),
         .left_ins    (left_ins_w[i]),
         .right_entry (right_w[i]),
         .entry       (entries[i]),
         .ins         (ins_w[i])
      );
   end

   always_comb begin
      count_in            = count_ff;
      rsp_out_id_in       = '0;
      rsp_out_priority_in = '0;
      if (req_opcode == spq_pkg::OP_ENQ) begin
         if (full) begin
            rsp_status_in = spq_pkg::ST_FULL;
         end else begin
            rsp_status_in = spq_pkg::ST_ENQUEUED;
            count_in      = count_ff + 1'b1;
         end
      end else begin
         if (empty) begin
            rsp_status_in = spq_pkg::ST_EMPTY;
         end else begin
            rsp_status_in       = spq_pkg::ST_DEQUEUED;
            rsp_out_id_in       = entries[0].id;
            rsp_out_priority_in = entries[0].prio;
            count_in            = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_out_id_ff       <= rsp_out_id_in;
         rsp_out_priority_ff <= rsp_out_priority_in;
         rsp_occupancy_ff    <= spq_pkg::OCC_BITS'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;

`ifndef SYNTHESIS
   a_rsp_follows_start : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing response beat");
   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("unexpected response beat");
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("count disagrees with slot valid bits");
   a_slots_packed : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("valid slots not packed toward head");
   a_full_occupancy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spq_pkg::ST_FULL) |->
      rsp_occupancy == spq_pkg::OCC_BITS'(spq_pkg::DEPTH))
      else $error("full reported below capacity");
`endif

endmodule

### sv/spq_cell.sv
module spq_cell (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::cmd_type   cmd,
   input  spq_pkg::entry_type left_entry,
   input  logic              left_ins,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic              ins
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new entry lands at this slot or at one nearer the head
   assign ins   = !entry_ff.valid || (entry_ff.prio < cmd.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq && ins) begin
         if (left_ins) begin
            entry_in = left_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.id    = cmd.id;
            entry_in.prio  = cmd.prio;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
